// ----- hw/rtl/mdt_pkg.sv -----
`default_nettype none

package mdt_pkg;

    // offsets stop growing here and later bytes are bad tokens
    localparam logic [16:0] MAX_DESC_LENGTH = 17'd65535;

    localparam logic [7:0] CH_LPAREN  = 8'h28;  // '('
    localparam logic [7:0] CH_RPAREN  = 8'h29;  // ')'
    localparam logic [7:0] CH_SEMI    = 8'h3B;  // ';'
    localparam logic [7:0] CH_CLASS   = 8'h4C;  // 'L'
    localparam logic [7:0] CH_ARRAY   = 8'h5B;  // '['
    localparam logic [7:0] VOID_TOKEN = 8'h56;  // 'V'

    localparam logic [3:0] KIND_CLASS = 4'd8;
    localparam logic [3:0] KIND_VOID  = 4'd9;
    localparam logic [7:0] SAT_MAX    = 8'd255;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_ARGS = 3'd1,
        PH_RET  = 3'd2,
        PH_DONE = 3'd3,
        PH_SKIP = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        IN_IDLE  = 2'd0,
        IN_ARRAY = 2'd1,
        IN_CLASS = 2'd2
    } inside_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_OPEN  = 3'd1,
        ST_NO_CLOSE = 3'd2,
        ST_BAD      = 3'd3,
        ST_UNTERM   = 3'd4
    } status_t;

    typedef struct packed {
        phase_t      phase;
        inside_t     in_type;
        logic [15:0] pos;
        logic [15:0] type_start;
        logic [7:0]  brackets;
        logic [7:0]  arg_count;
        status_t     sticky;
        logic [3:0]  return_kind;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_OPEN,
        in_type:     IN_IDLE,
        pos:         16'd0,
        type_start:  16'd0,
        brackets:    8'd0,
        arg_count:   8'd0,
        sticky:      ST_OK,
        return_kind: 4'd0
    };

    typedef struct packed {
        logic [3:0]  type_kind;
        logic [7:0]  array_depth;
        logic [15:0] start_offset;
        logic [15:0] type_length;
        logic [7:0]  argument_number;
        logic        is_return;
        status_t     status;
        logic        final_result;
    } result_t;

    // bit 3 set for a primitive letter, low bits give its code
    function automatic logic [3:0] prim_decode(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            8'h42:   r = 4'b1000;  // B
            8'h43:   r = 4'b1001;  // C
            8'h44:   r = 4'b1010;  // D
            8'h46:   r = 4'b1011;  // F
            8'h49:   r = 4'b1100;  // I
            8'h4A:   r = 4'b1101;  // J
            8'h53:   r = 4'b1110;  // S
            8'h5A:   r = 4'b1111;  // Z
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mdt_parse.sv -----
`default_nettype none

module mdt_parse (
    input  wire mdt_pkg::state_t  state,
    input  wire logic [7:0]       character,
    input  wire logic             end_of_string,
    output mdt_pkg::state_t       state_next,
    output logic                  res_valid,
    output mdt_pkg::result_t      res
);
    import mdt_pkg::*;

    logic       allow_void;
    logic       f_done;
    logic       f_bad;
    logic [3:0] f_kind;
    inside_t    f_inside;
    logic [15:0] f_start;
    logic [7:0] f_brk;
    logic [7:0] brk_base;
    logic [3:0] prim;
    logic       over;
    state_t     upd;
    status_t    fin_status;

    assign allow_void = (state.phase == PH_RET);
    assign prim       = prim_decode(character);
    assign over       = ({1'b0, state.pos} >= MAX_DESC_LENGTH);

    // one byte of a field or return type
    always_comb
    begin
        f_done   = 1'b0;
        f_bad    = 1'b0;
        f_kind   = 4'd0;
        f_inside = state.in_type;
        f_start  = state.type_start;
        f_brk    = state.brackets;
        brk_base = (state.in_type == IN_IDLE) ? 8'd0 : state.brackets;
        if (state.in_type == IN_CLASS)
        begin
            if (character == CH_SEMI)
            begin
                f_inside = IN_IDLE;
                f_done   = 1'b1;
                f_kind   = KIND_CLASS;
            end
        end
        else
        begin
            if (state.in_type == IN_IDLE)
            begin
                f_start = state.pos;
                f_brk   = 8'd0;
            end
            if (state.in_type == IN_IDLE && allow_void && character == VOID_TOKEN)
            begin
                f_done = 1'b1;
                f_kind = KIND_VOID;
            end
            else if (prim[3])
            begin
                f_inside = IN_IDLE;
                f_done   = 1'b1;
                f_kind   = {1'b0, prim[2:0]};
            end
            else if (character == CH_CLASS)
            begin
                f_inside = IN_CLASS;
            end
            else if (character == CH_ARRAY)
            begin
                f_inside = IN_ARRAY;
                f_brk    = (brk_base < SAT_MAX) ? brk_base + 8'd1 : brk_base;
            end
            else
            begin
                f_inside = IN_IDLE;
                f_bad    = 1'b1;
            end
        end
    end

    always_comb
    begin
        upd        = state;
        res_valid  = 1'b0;
        res        = '0;
        fin_status = ST_OK;
        if (over)
        begin
            if (upd.sticky == ST_OK)
                upd.sticky = ST_BAD;
            upd.phase   = PH_SKIP;
            upd.in_type = IN_IDLE;
        end
        else
        begin
            case (state.phase)
                PH_OPEN:
                begin
                    if (character == CH_LPAREN)
                        upd.phase = PH_ARGS;
                    else
                    begin
                        upd.sticky  = ST_NO_OPEN;
                        upd.phase   = PH_SKIP;
                        upd.in_type = IN_IDLE;
                    end
                end
                PH_ARGS:
                begin
                    if (character == CH_RPAREN)
                    begin
                        if (state.in_type == IN_IDLE)
                            upd.phase = PH_RET;
                        else
                        begin
                            if (upd.sticky == ST_OK)
                                upd.sticky = (state.in_type == IN_ARRAY) ? ST_BAD : ST_UNTERM;
                            upd.phase   = PH_SKIP;
                            upd.in_type = IN_IDLE;
                        end
                    end
                    else
                    begin
                        upd.in_type    = f_inside;
                        upd.type_start = f_start;
                        upd.brackets   = f_brk;
                        if (f_bad)
                        begin
                            if (upd.sticky == ST_OK)
                                upd.sticky = ST_BAD;
                            upd.phase   = PH_SKIP;
                            upd.in_type = IN_IDLE;
                        end
                        else if (f_done)
                        begin
                            if (!end_of_string)
                            begin
                                res_valid           = 1'b1;
                                res.type_kind       = f_kind;
                                res.array_depth     = f_brk;
                                res.start_offset    = f_start;
                                res.type_length     = state.pos - f_start + 16'd1;
                                res.argument_number = state.arg_count;
                            end
                            if (state.arg_count < SAT_MAX)
                                upd.arg_count = state.arg_count + 8'd1;
                        end
                    end
                end
                PH_RET:
                begin
                    upd.in_type    = f_inside;
                    upd.type_start = f_start;
                    upd.brackets   = f_brk;
                    if (f_bad)
                    begin
                        if (upd.sticky == ST_OK)
                            upd.sticky = ST_BAD;
                        upd.phase   = PH_SKIP;
                        upd.in_type = IN_IDLE;
                    end
                    else if (f_done)
                    begin
                        upd.return_kind = f_kind;
                        upd.phase       = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    if (upd.sticky == ST_OK)
                        upd.sticky = ST_BAD;
                    upd.phase   = PH_SKIP;
                    upd.in_type = IN_IDLE;
                end
                default:
                begin
                    // skipping to the flagged byte after an error
                end
            endcase
            if (!end_of_string)
                upd.pos = state.pos + 16'd1;
        end

        if (end_of_string)
        begin
            fin_status = upd.sticky;
            if (fin_status == ST_OK)
            begin
                if (upd.phase == PH_ARGS)
                    fin_status = ST_NO_CLOSE;
                else if (upd.phase == PH_RET)
                    fin_status = (upd.in_type == IN_CLASS) ? ST_UNTERM : ST_BAD;
                else if (upd.phase != PH_DONE)
                    fin_status = ST_BAD;
            end
            res       = '0;
            res_valid = 1'b1;
            if (fin_status == ST_OK)
            begin
                res.type_kind    = upd.return_kind;
                res.array_depth  = upd.brackets;
                res.start_offset = upd.type_start;
                res.type_length  = state.pos - upd.type_start + 16'd1;
            end
            res.argument_number = upd.arg_count;
            res.is_return       = 1'b1;
            res.status          = fin_status;
            res.final_result    = 1'b1;
            state_next          = STATE_RESET;
        end
        else
        begin
            state_next = upd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mdt_outbuf.sv -----
`default_nettype none

module mdt_outbuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mdt_pkg::result_t push_data,
    output logic                  push_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mdt_pkg::result_t      out_data
);
    import mdt_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
            skid_data_reg <= push_data;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/method_descriptor_tokenizer.sv -----
`default_nettype none
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------------
// s_*      | in  | s_tvalid/s_tready  | descriptor byte, tlast = end of string
// m_*      | out | m_tvalid/m_tready  | one argument or return type per request
//
// one byte per cycle while s_tready is high; each byte is classified and the parse state
// updated by a single pass of logic between the state register and the result
// buffer, so one request can follow another on every clock edge
// a two-entry output buffer keeps the input open for one more request while a
// result waits; s_tready drops only when both entries are full
// rst_n is asynchronous; it returns the parser to expecting '(' at offset zero
// the flagged last byte always yields the final result and clears the parser

module method_descriptor_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic        s_tlast,   // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] type_kind, [11:4] array_depth, [27:12] start_offset,
    // [43:28] type_length, [51:44] argument_number, [54:52] status, [55] zero
    output logic [55:0]      m_tdata,
    output logic             m_tuser,   // is_return
    output logic             m_tlast    // final_result
);
    import mdt_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    in_fire;

    assign in_fire = s_tvalid && s_tready;

    // per-byte classification and next parse state
    mdt_parse u_parse (
        .state         (state_reg),
        .character     (s_tdata),
        .end_of_string (s_tlast),
        .state_next    (state_next),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (in_fire)
            state_reg <= state_next;
    end

    // result register plus skid entry
    mdt_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire && res_valid),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {1'b0, out_res.status, out_res.argument_number, out_res.type_length,
                      out_res.start_offset, out_res.array_depth, out_res.type_kind};
    assign m_tuser = out_res.is_return;
    assign m_tlast = out_res.final_result;

`ifndef SYNTHESIS
    // skid entry only fills behind a stalled output entry
    assert property (@(posedge clk) disable iff (!rst_n)
        u_outbuf.skid_valid_reg |-> m_tvalid)
        else $error("skid entry valid while output empty");

    // argument results never carry an error status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[54:52] == ST_OK && !m_tuser))
        else $error("argument result with status or return flag");

    // the last byte of a descriptor sends the parser back to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (state_reg.phase == PH_OPEN && state_reg.pos == 16'd0))
        else $error("parser not cleared after end of string");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import mdt_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 650;

    // outcomes of one step through a field type
    localparam int PENDING = -1;
    localparam int BADTOK  = -2;

    // primitive letters, position in the string is the kind code
    localparam string PRIM_LETTERS = "BCDFIJSZ";

    // one descriptor byte waiting to be sent
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;   // wait for every expected result before sending
    } desc_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    method_descriptor_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // descriptor bytes still to be sent, and the parsed types still to come back
    desc_byte_t desc_bytes[$];
    result_t    expected_types[$];

    bit hold_next;
    int bytes_queued;
    int bytes_sent;
    int descriptors_done;
    int faulty_descriptors;
    int results_checked;
    int mismatches;
    int cycles;

    // -------------------------------------------------------------------------
    // parser state as predicted by the bench
    // -------------------------------------------------------------------------
    phase_t      ph;
    inside_t     ins;
    logic [15:0] at_pos;
    logic [15:0] tok_start;
    logic [7:0]  depth;
    logic [7:0]  argc;
    status_t     sticky;
    logic [3:0]  ret_kind;

    task automatic clear_parser();
        ph        = PH_OPEN;
        ins       = IN_IDLE;
        at_pos    = 16'd0;
        tok_start = 16'd0;
        depth     = 8'd0;
        argc      = 8'd0;
        sticky    = ST_OK;
        ret_kind  = 4'd0;
    endtask

    // first error wins, everything up to the end flag is then skipped
    task automatic flag_error(input status_t code);
        if (sticky == ST_OK)
            sticky = code;
        ph  = PH_SKIP;
        ins = IN_IDLE;
    endtask

    function automatic int letter_kind(input logic [7:0] c);
        for (int i = 0; i < 8; i++)
            if (PRIM_LETTERS[i] == c)
                return i;
        return -1;
    endfunction

    // one byte of a field type (or the return type); kind is set once the type completes
    task automatic step_type(input logic [7:0] c, input logic [15:0] p, input bit void_ok,
                             output int kind);
        int prim;
        prim = letter_kind(c);
        kind = PENDING;
        if (ins == IN_CLASS)
        begin
            if (c == CH_SEMI)
            begin
                ins  = IN_IDLE;
                kind = KIND_CLASS;
            end
            return;
        end
        if (ins == IN_IDLE)
        begin
            // a new type starts here
            tok_start = p;
            depth     = 8'd0;
            if (void_ok && c == VOID_TOKEN)
            begin
                kind = KIND_VOID;
                return;
            end
        end
        if (prim >= 0)
        begin
            ins  = IN_IDLE;
            kind = prim;
        end
        else if (c == CH_CLASS)
            ins = IN_CLASS;
        else if (c == CH_ARRAY)
        begin
            ins = IN_ARRAY;
            if (depth != SAT_MAX)
                depth++;
        end
        else
        begin
            ins  = IN_IDLE;
            kind = BADTOK;
        end
    endtask

    // advances the predicted parser by one accepted byte and queues what it yields
    task automatic tokenize_byte(input logic [7:0] c, input logic eos);
        logic [15:0] p;
        int          kind;
        result_t     r;
        status_t     st;
        p = at_pos;
        r = '0;
        if ({1'b0, p} >= MAX_DESC_LENGTH)
            flag_error(ST_BAD);   // overlong: offset frozen, byte rejected
        else
        begin
            case (ph)
                PH_OPEN:
                    if (c == CH_LPAREN)
                        ph = PH_ARGS;
                    else
                        flag_error(ST_NO_OPEN);
                PH_ARGS:
                    if (c == CH_RPAREN)
                    begin
                        if (ins == IN_IDLE)
                            ph = PH_RET;
                        else if (ins == IN_ARRAY)
                            flag_error(ST_BAD);
                        else
                            flag_error(ST_UNTERM);
                    end
                    else
                    begin
                        step_type(c, p, 1'b0, kind);
                        if (kind == BADTOK)
                            flag_error(ST_BAD);
                        else if (kind >= 0)
                        begin
                            // an argument finishing on the end byte is counted but not reported
                            if (!eos)
                            begin
                                r.type_kind       = kind[3:0];
                                r.array_depth     = depth;
                                r.start_offset    = tok_start;
                                r.type_length     = p - tok_start + 16'd1;
                                r.argument_number = argc;
                                expected_types.push_back(r);
                            end
                            if (argc != SAT_MAX)
                                argc++;
                        end
                    end
                PH_RET:
                begin
                    step_type(c, p, 1'b1, kind);
                    if (kind == BADTOK)
                        flag_error(ST_BAD);
                    else if (kind >= 0)
                    begin
                        ret_kind = kind[3:0];
                        ph       = PH_DONE;
                    end
                end
                PH_DONE:
                    flag_error(ST_BAD);   // trailing byte after the return type
                default:
                    ;
            endcase
            if (!eos && {1'b0, p} < MAX_DESC_LENGTH)
                at_pos = p + 16'd1;
        end

        if (eos)
        begin
            st = sticky;
            if (st == ST_OK)
            begin
                if (ph == PH_ARGS)
                    st = ST_NO_CLOSE;
                else if (ph == PH_RET)
                    st = (ins == IN_CLASS) ? ST_UNTERM : ST_BAD;
                else if (ph != PH_DONE)
                    st = ST_BAD;
            end
            r = '0;
            if (st == ST_OK)
            begin
                r.type_kind    = ret_kind;
                r.array_depth  = depth;
                r.start_offset = tok_start;
                r.type_length  = p - tok_start + 16'd1;
            end
            else
                faulty_descriptors++;
            r.argument_number = argc;
            r.is_return       = 1'b1;
            r.status          = st;
            r.final_result    = 1'b1;
            expected_types.push_back(r);
            descriptors_done++;
            clear_parser();
        end
    endtask

    // -------------------------------------------------------------------------
    // stimulus building
    // -------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c, input logic last);
        desc_byte_t b;
        b.ch      = c;
        b.last    = last;
        b.hold    = hold_next;
        hold_next = 1'b0;
        desc_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic add_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], ends && (i == s.len() - 1));
    endtask

    task automatic add_run(input logic [7:0] c, input int n);
        repeat (n) add_byte(c, 1'b0);
    endtask

    // a well-formed field type: optional '[' prefixes on a primitive or a class
    task automatic add_field(ref logic [7:0] d[$]);
        int         r;
        int         n;
        logic [7:0] b;
        r = $urandom_range(99);
        n = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        repeat (n) d.push_back(CH_ARRAY);
        if ($urandom_range(9) < 7)
            d.push_back(PRIM_LETTERS[$urandom_range(7)]);
        else
        begin
            d.push_back(CH_CLASS);
            repeat ($urandom_range(5))
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_SEMI || b == CH_RPAREN);
                d.push_back(b);
            end
            d.push_back(CH_SEMI);
        end
    endtask

    // mostly well-formed descriptors, the rest corrupted, cut short, padded or pure noise
    task automatic random_descriptor();
        logic [7:0] d[$];
        int         r;
        d.push_back(CH_LPAREN);
        repeat ($urandom_range(5)) add_field(d);
        d.push_back(CH_RPAREN);
        if ($urandom_range(3) == 0)
            d.push_back(VOID_TOKEN);
        else
            add_field(d);
        r = $urandom_range(99);
        if (r < 75)
            ;
        else if (r < 85)
            d[$urandom_range(d.size() - 1)] = 8'($urandom_range(255));
        else if (r < 92)
            d = d[0:$urandom_range(d.size() - 1)];
        else if (r < 96)
            d.push_back(8'($urandom_range(255)));
        else
        begin
            d.delete();
            repeat ($urandom_range(1, 6)) d.push_back(8'($urandom_range(255)));
        end
        foreach (d[k])
            add_byte(d[k], k == d.size() - 1);
    endtask

    // mostly back to back with short gaps, a few long ones, and idle-free bursts
    function automatic int next_gap(inout bit burst);
        int r;
        if ($urandom_range(63) == 0)
            burst = !burst;
        if (burst)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // -------------------------------------------------------------------------
    // driver: sends descriptor bytes, predicts on each accepted request
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive
        desc_byte_t nxt;
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        int         src_gap;
        bit         src_burst;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= 8'h00;
            s_tlast   <= 1'b0;
            src_gap   = 0;
            src_burst = 1'b0;
            clear_parser();
        end
        else
        begin
            nv = s_tvalid;
            nd = s_tdata;
            nl = s_tlast;
            if (s_tvalid && s_tready)
            begin
                tokenize_byte(s_tdata, s_tlast);
                bytes_sent++;
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (desc_bytes.size() > 0 &&
                         !(desc_bytes[0].hold && expected_types.size() > 0))
                begin
                    nxt     = desc_bytes.pop_front();
                    nv      = 1'b1;
                    nd      = nxt.ch;
                    nl      = nxt.last;
                    src_gap = next_gap(src_burst);
                end
            end
            s_tvalid <= nv;
            s_tdata  <= nd;
            s_tlast  <= nl;
        end
    end

    // -------------------------------------------------------------------------
    // monitor: stalls the result side and checks each accepted request
    // -------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        int      sink_gap;
        bit      sink_burst;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_gap   = 0;
            sink_burst = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (expected_types.size() == 0)
                begin
                    $display("%0t: unexpected result, nothing predicted, m_tdata=%h tuser=%b tlast=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_types.pop_front();
                    check_field("type_kind", want.type_kind, m_tdata[3:0]);
                    check_field("array_depth", want.array_depth, m_tdata[11:4]);
                    check_field("start_offset", want.start_offset, m_tdata[27:12]);
                    check_field("type_length", want.type_length, m_tdata[43:28]);
                    check_field("argument_number", want.argument_number, m_tdata[51:44]);
                    check_field("status", want.status, m_tdata[54:52]);
                    check_field("is_return", want.is_return, m_tuser);
                    check_field("final_result", want.final_result, m_tlast);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_gap = next_gap(sink_burst);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d bytes accepted, %0d results outstanding",
                     cycles, bytes_sent, bytes_queued, expected_types.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // stimulus and end of run
    // -------------------------------------------------------------------------
    initial
    begin
        int base;

        // directed: every primitive, void, arrays, classes and each error path
        add_text("(BCDFIJSZ)V", 1);
        add_text("([[La;)[J", 1);
        add_text("(I)Lx;", 1);
        add_text("()I", 1);        // single-letter return type
        add_byte(8'h00, 1'b1);      // no opening paren
        add_text("(", 0);           // byte with every bit set is a bad token
        add_byte(8'hFF, 1'b0);
        add_text(")V", 1);
        add_text("(", 1);           // ends before ')'
        add_text("(I", 1);          // argument completes on the end byte
        add_text("([)V", 1);        // ')' inside an array prefix
        add_text("(La)V", 1);       // ')' inside a class name
        add_text("()VI", 1);        // byte after a complete return type
        add_text("()", 1);          // missing return type
        add_text("()Q", 1);         // unknown return letter
        add_text("()La", 1);        // ends inside the return class

        // saturating counters: argument count and array depth
        hold_next = 1'b1;
        add_text("(", 0);
        add_run("I", 300);
        add_text(")V", 1);
        add_text("(", 0);
        add_run(CH_ARRAY, 300);
        add_text("I)", 0);
        add_run(CH_ARRAY, 300);
        add_text("J", 1);

        // overlong descriptor runs past the last legal offset inside a class name
        hold_next = 1'b1;
        add_text("(L", 0);
        add_run("a", 66000);
        add_text(";)V", 1);

        // random part, sent only once everything above has drained
        hold_next = 1'b1;
        base = bytes_queued;
        while (bytes_queued - base < RANDOM_BYTES)
        begin
            if ($urandom_range(15) == 0)
                hold_next = 1'b1;
            random_descriptor();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent != bytes_queued)
            @(posedge clk);
        while (expected_types.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tokenized %0d descriptors from %0d bytes, %0d of them with a parse error",
                 descriptors_done, bytes_sent, faulty_descriptors);
        $display("checked %0d argument and return requests, %0d field mismatches",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
